>>> src/assert_macros.svh
// assertion macros used by the tokenizer back end rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define STT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tokenizer invariant violated");

// condition in one cycle forces the consequence in the next
`define STT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer sequence violated");

`endif

>>> src/stt_pkg.sv
// types, codes and keyword table for the source text tokenizer
`default_nettype none

package stt_pkg;

    typedef enum logic [3:0] {
        M_IDLE,
        M_PLUS,
        M_SLASH,
        M_COMMENT,
        M_BAR,
        M_AMP,
        M_REL,
        M_EQ,
        M_COLON,
        M_STRING,
        M_IDENT,
        M_INT,
        M_DOT,
        M_REAL
    } mode_t;

    typedef enum logic [4:0] {
        CC_SPACE,
        CC_PLUS,
        CC_MINUS,
        CC_STAR,
        CC_DOT,
        CC_BROPEN,
        CC_BRCLOSE,
        CC_SEMI,
        CC_COMMA,
        CC_SLASH,
        CC_BAR,
        CC_AMP,
        CC_REL,
        CC_EQ,
        CC_COLON,
        CC_QUOTE,
        CC_ALPHA,
        CC_DIGIT,
        CC_OTHER
    } cls_t;

    localparam logic [5:0] K_ERROR   = 6'd0;
    localparam logic [5:0] K_END     = 6'd1;
    localparam logic [5:0] K_IDENT   = 6'd2;
    localparam logic [5:0] K_INT     = 6'd3;
    localparam logic [5:0] K_REAL    = 6'd4;
    localparam logic [5:0] K_STRING  = 6'd5;
    localparam logic [5:0] K_ADDOP   = 6'd6;
    localparam logic [5:0] K_INCR    = 6'd7;
    localparam logic [5:0] K_MULOP   = 6'd8;
    localparam logic [5:0] K_PERIOD  = 6'd9;
    localparam logic [5:0] K_BROPEN  = 6'd10;
    localparam logic [5:0] K_BRCLOSE = 6'd11;
    localparam logic [5:0] K_SEMI    = 6'd12;
    localparam logic [5:0] K_COMMA   = 6'd13;
    localparam logic [5:0] K_LOGOP   = 6'd14;
    localparam logic [5:0] K_RELOP   = 6'd15;
    localparam logic [5:0] K_ASSIGN  = 6'd16;
    localparam logic [5:0] K_DCOLON  = 6'd17;
    localparam logic [5:0] K_KEYWORD = 6'd18;

    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BAR    = 8'h7c;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;

    localparam int KW_SLOTS = 32;

    typedef struct packed {
        logic [7:0] code;
        logic       eoi;
        cls_t       cls;
        logic       newline;
        logic       kw_follow;
    } item_t;

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] len;
        logic       last;
    } result_t;

    function automatic logic [63:0] kw_text(int i);
        case (i)
            0:       return "false";
            1:       return "true";
            2:       return "while";
            3:       return "if";
            4:       return "else";
            5:       return "EXIT";
            6:       return "BEGIN";
            7:       return "THEN";
            8:       return "DO";
            9:       return "END";
            10:      return "static";
            11:      return "int";
            12:      return "anytype";
            13:      return "boolean";
            14:      return "void";
            15:      return "real";
            16:      return "String";
            17:      return "date";
            default: return 64'd0;
        endcase
    endfunction

    function automatic int kw_len(int i);
        logic [63:0] t;
        int n;
        t = kw_text(i);
        n = 0;
        for (int b = 0; b < 8; b++)
        begin
            if (t[8*b +: 8] != 8'd0)
            begin
                n = b + 1;
            end
        end
        return n;
    endfunction

    // character at position p of keyword i, counted from the left
    function automatic logic [7:0] kw_char(int i, int p);
        logic [63:0] t;
        int l;
        t = kw_text(i);
        l = kw_len(i);
        if (p < l)
        begin
            return t[8*(l-1-p) +: 8];
        end
        return 8'd0;
    endfunction

endpackage

`default_nettype wire

>>> src/stt_front.sv
// front end: accepts character beats and classifies them
`default_nettype none

module stt_front import stt_pkg::*;
(
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tuser,
    output item_t           item,
    output logic            item_valid,
    input  wire logic       item_ready
);

    function automatic cls_t classify(logic [7:0] c);
        cls_t k;
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)
            k = CC_SPACE;
        else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f)
            k = CC_ALPHA;
        else if (c >= 8'h30 && c <= 8'h39)
            k = CC_DIGIT;
        else
        begin
            case (c)
                CH_PLUS:  k = CC_PLUS;
                8'h2d:    k = CC_MINUS;
                8'h2a:    k = CC_STAR;
                CH_DOT:   k = CC_DOT;
                8'h7b:    k = CC_BROPEN;
                8'h7d:    k = CC_BRCLOSE;
                8'h3b:    k = CC_SEMI;
                8'h2c:    k = CC_COMMA;
                CH_SLASH: k = CC_SLASH;
                CH_BAR:   k = CC_BAR;
                CH_AMP:   k = CC_AMP;
                8'h3c:    k = CC_REL;
                8'h3e:    k = CC_REL;
                CH_EQ:    k = CC_EQ;
                CH_COLON: k = CC_COLON;
                CH_QUOTE: k = CC_QUOTE;
                default:  k = CC_OTHER;
            endcase
        end
        return k;
    endfunction

    always_comb
    begin
        item.code      = s_tdata;
        item.eoi       = s_tuser;
        item.cls       = classify(s_tdata);
        item.newline   = (s_tdata == CH_LF);
        item.kw_follow = (s_tdata == CH_SPACE) || (s_tdata == CH_LPAREN);
        item_valid     = s_tvalid;
        s_tready       = item_ready;
    end

endmodule

`default_nettype wire

>>> src/stt_queue.sv
// two-entry queue of classified beats between front and back
`default_nettype none

module stt_queue import stt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t push_item,
    input  wire logic  push_valid,
    output logic       push_ready,
    output item_t      pop_item,
    output logic       pop_valid,
    input  wire logic  pop_ready
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    logic        pop;

    always_comb
    begin
        push_ready  = (cnt_reg != 2'd2);
        pop_valid   = (cnt_reg != 2'd0);
        pop_item    = slot_reg[rd_ptr_reg];
        push        = push_valid && push_ready;
        pop         = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> src/stt_back.sv
// back end: scanner state machine and result buffer
`default_nettype none
`include "assert_macros.svh"

module stt_back import stt_pkg::*;
#(
    parameter int KEYWORD_COUNT = 18,
    parameter int LENGTH_BITS   = 8
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t q_item,
    input  wire logic  q_valid,
    output logic       q_pop,
    output result_t    m_res,
    output logic       m_valid,
    input  wire logic  m_ready
);

    localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
    localparam logic [KEYWORD_COUNT-1:0] KW_ALL  = '1;

    mode_t                    mode_reg;
    mode_t                    mode_next;
    logic [LENGTH_BITS-1:0]   count_reg;
    logic [LENGTH_BITS-1:0]   count_next;
    logic [KEYWORD_COUNT-1:0] cand_reg;
    logic [KEYWORD_COUNT-1:0] cand_next;
    logic                     finished_reg;
    logic                     finished_next;

    result_t                  rf_reg [4];
    logic [1:0]               wr_ptr_reg;
    logic [1:0]               rd_ptr_reg;
    logic [2:0]               cnt_reg;
    logic [2:0]               cnt_next;

    logic                     fire;
    logic                     out_pop;
    logic                     a_v;
    logic                     b_v;
    result_t                  a_res;
    result_t                  b_res;
    result_t                  slot0;
    result_t                  slot1;
    logic [1:0]               push_n;
    logic                     do_start;
    logic [LENGTH_BITS-1:0]   count_inc;
    logic [7:0]               c;

    function automatic logic [7:0] sat_len(logic [LENGTH_BITS-1:0] v);
        if (32'(v) > 32'd255)
            return 8'd255;
        return 8'(v);
    endfunction

    function automatic logic [LENGTH_BITS-1:0] bump(logic [LENGTH_BITS-1:0] v);
        if (v == LEN_MAX)
            return v;
        return v + LENGTH_BITS'(1);
    endfunction

    function automatic logic [KEYWORD_COUNT-1:0] track(logic [KEYWORD_COUNT-1:0] cand,
                                                       logic [LENGTH_BITS-1:0] p,
                                                       logic [7:0] ch);
        logic [KEYWORD_COUNT-1:0] r;
        r = cand;
        for (int i = 0; i < KEYWORD_COUNT; i++)
        begin
            if (!(32'(p) < 32'(kw_len(i))) || (kw_char(i, int'(p[2:0])) != ch))
            begin
                r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] ident_kind(logic [KEYWORD_COUNT-1:0] cand,
                                              logic [LENGTH_BITS-1:0] cnt,
                                              logic ok);
        logic [5:0] k;
        k = K_IDENT;
        if (ok)
        begin
            for (int i = KEYWORD_COUNT - 1; i >= 0; i--)
            begin
                if (cand[i] && (32'(cnt) == 32'(kw_len(i))))
                begin
                    k = K_KEYWORD + 6'(i);
                end
            end
        end
        return k;
    endfunction

    always_comb
    begin
        c             = q_item.code;
        fire          = q_valid && (cnt_reg <= 3'd2);
        q_pop         = fire;
        count_inc     = bump(count_reg);
        mode_next     = mode_reg;
        count_next    = count_reg;
        cand_next     = cand_reg;
        finished_next = finished_reg;
        a_v           = 1'b0;
        a_res         = '0;
        b_v           = 1'b0;
        b_res         = '0;
        do_start      = 1'b0;

        if (finished_reg)
        begin
            b_v        = 1'b1;
            b_res.kind = K_END;
        end
        else if (q_item.eoi)
        begin
            a_v = 1'b1;
            case (mode_reg)
                M_PLUS:
                begin
                    a_res.kind = K_ADDOP;
                    a_res.len  = 8'd1;
                end
                M_SLASH:
                begin
                    a_res.kind = K_MULOP;
                    a_res.len  = 8'd1;
                end
                M_BAR, M_AMP, M_EQ, M_COLON:
                begin
                    a_res.kind = K_ERROR;
                    a_res.len  = 8'd1;
                end
                M_REL:
                begin
                    a_res.kind = K_RELOP;
                    a_res.len  = 8'd1;
                end
                M_STRING, M_DOT:
                begin
                    a_res.kind = K_ERROR;
                    a_res.len  = sat_len(count_reg);
                end
                M_IDENT:
                begin
                    a_res.kind = ident_kind(cand_reg, count_reg, 1'b0);
                    a_res.len  = sat_len(count_reg);
                end
                M_INT:
                begin
                    a_res.kind = K_INT;
                    a_res.len  = sat_len(count_reg);
                end
                M_REAL:
                begin
                    a_res.kind = K_REAL;
                    a_res.len  = sat_len(count_reg);
                end
                default:
                begin
                    a_v = 1'b0;
                end
            endcase
            b_v           = 1'b1;
            b_res.kind    = K_END;
            finished_next = 1'b1;
            mode_next     = M_IDLE;
            count_next    = '0;
            cand_next     = KW_ALL;
        end
        else
        begin
            case (mode_reg)
                M_PLUS:
                begin
                    a_v = 1'b1;
                    if (c == CH_PLUS)
                    begin
                        a_res.kind = K_INCR;
                        a_res.len  = 8'd2;
                        mode_next  = M_IDLE;
                    end
                    else
                    begin
                        a_res.kind = K_ADDOP;
                        a_res.len  = 8'd1;
                        do_start   = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (c == CH_SLASH)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        a_v        = 1'b1;
                        a_res.kind = K_MULOP;
                        a_res.len  = 8'd1;
                        do_start   = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (q_item.newline)
                    begin
                        mode_next = M_IDLE;
                    end
                end
                M_BAR, M_AMP:
                begin
                    a_v       = 1'b1;
                    mode_next = M_IDLE;
                    if (c == ((mode_reg == M_BAR) ? CH_BAR : CH_AMP))
                    begin
                        a_res.kind = K_LOGOP;
                        a_res.len  = 8'd2;
                    end
                    else
                    begin
                        a_res.kind = K_ERROR;
                        a_res.len  = 8'd1;
                    end
                end
                M_REL:
                begin
                    a_v        = 1'b1;
                    a_res.kind = K_RELOP;
                    if (c == CH_EQ)
                    begin
                        a_res.len = 8'd2;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        a_res.len = 8'd1;
                        do_start  = 1'b1;
                    end
                end
                M_EQ:
                begin
                    a_v       = 1'b1;
                    mode_next = M_IDLE;
                    if (c == CH_EQ)
                    begin
                        a_res.kind = K_RELOP;
                        a_res.len  = 8'd2;
                    end
                    else
                    begin
                        a_res.kind = K_ERROR;
                        a_res.len  = 8'd1;
                    end
                end
                M_COLON:
                begin
                    a_v       = 1'b1;
                    mode_next = M_IDLE;
                    if (c == CH_EQ)
                    begin
                        a_res.kind = K_ASSIGN;
                        a_res.len  = 8'd2;
                    end
                    else if (c == CH_COLON)
                    begin
                        a_res.kind = K_DCOLON;
                        a_res.len  = 8'd2;
                    end
                    else
                    begin
                        a_res.kind = K_ERROR;
                        a_res.len  = 8'd1;
                    end
                end
                M_STRING:
                begin
                    if (c == CH_QUOTE || q_item.newline)
                    begin
                        a_v        = 1'b1;
                        a_res.kind = (c == CH_QUOTE) ? K_STRING : K_ERROR;
                        a_res.len  = sat_len(count_reg);
                        mode_next  = M_IDLE;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                M_IDENT:
                begin
                    if (q_item.cls == CC_ALPHA || q_item.cls == CC_DIGIT)
                    begin
                        cand_next  = track(cand_reg, count_reg, c);
                        count_next = count_inc;
                    end
                    else
                    begin
                        a_v        = 1'b1;
                        a_res.kind = ident_kind(cand_reg, count_reg, q_item.kw_follow);
                        a_res.len  = sat_len(count_reg);
                        do_start   = 1'b1;
                    end
                end
                M_INT:
                begin
                    if (q_item.cls == CC_DIGIT)
                    begin
                        count_next = count_inc;
                    end
                    else if (c == CH_DOT)
                    begin
                        count_next = count_inc;
                        mode_next  = M_DOT;
                    end
                    else
                    begin
                        a_v        = 1'b1;
                        a_res.kind = K_INT;
                        a_res.len  = sat_len(count_reg);
                        do_start   = 1'b1;
                    end
                end
                M_DOT:
                begin
                    count_next = count_inc;
                    if (q_item.cls == CC_DIGIT)
                    begin
                        mode_next = M_REAL;
                    end
                    else
                    begin
                        a_v        = 1'b1;
                        a_res.kind = K_ERROR;
                        a_res.len  = sat_len(count_inc - LENGTH_BITS'(1));
                        mode_next  = M_IDLE;
                    end
                end
                M_REAL:
                begin
                    if (q_item.cls == CC_DIGIT)
                    begin
                        count_next = count_inc;
                    end
                    else
                    begin
                        a_v        = 1'b1;
                        a_res.kind = K_REAL;
                        a_res.len  = sat_len(count_reg);
                        do_start   = 1'b1;
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase

            // lookahead character opens the next token
            if (do_start)
            begin
                mode_next  = M_IDLE;
                count_next = '0;
                cand_next  = KW_ALL;
                b_res.len  = 8'd1;
                case (q_item.cls)
                    CC_SPACE:
                    begin
                    end
                    CC_PLUS:    mode_next = M_PLUS;
                    CC_SLASH:   mode_next = M_SLASH;
                    CC_BAR:     mode_next = M_BAR;
                    CC_AMP:     mode_next = M_AMP;
                    CC_REL:     mode_next = M_REL;
                    CC_EQ:      mode_next = M_EQ;
                    CC_COLON:   mode_next = M_COLON;
                    CC_QUOTE:   mode_next = M_STRING;
                    CC_MINUS:
                    begin
                        b_v        = 1'b1;
                        b_res.kind = K_ADDOP;
                    end
                    CC_STAR:
                    begin
                        b_v        = 1'b1;
                        b_res.kind = K_MULOP;
                    end
                    CC_DOT:
                    begin
                        b_v        = 1'b1;
                        b_res.kind = K_PERIOD;
                    end
                    CC_BROPEN:
                    begin
                        b_v        = 1'b1;
                        b_res.kind = K_BROPEN;
                    end
                    CC_BRCLOSE:
                    begin
                        b_v        = 1'b1;
                        b_res.kind = K_BRCLOSE;
                    end
                    CC_SEMI:
                    begin
                        b_v        = 1'b1;
                        b_res.kind = K_SEMI;
                    end
                    CC_COMMA:
                    begin
                        b_v        = 1'b1;
                        b_res.kind = K_COMMA;
                    end
                    CC_ALPHA:
                    begin
                        mode_next  = M_IDENT;
                        cand_next  = track(KW_ALL, '0, c);
                        count_next = LENGTH_BITS'(1);
                    end
                    CC_DIGIT:
                    begin
                        mode_next  = M_INT;
                        count_next = LENGTH_BITS'(1);
                    end
                    default:
                    begin
                        b_v        = 1'b1;
                        b_res.kind = K_ERROR;
                    end
                endcase
            end
        end

        slot0  = '0;
        slot1  = '0;
        push_n = 2'd0;
        if (a_v && b_v)
        begin
            slot0      = a_res;
            slot1      = b_res;
            slot1.last = 1'b1;
            push_n     = 2'd2;
        end
        else if (a_v || b_v)
        begin
            slot0      = a_v ? a_res : b_res;
            slot0.last = 1'b1;
            push_n     = 2'd1;
        end
        if (!fire)
        begin
            push_n = 2'd0;
        end

        m_valid  = (cnt_reg != 3'd0);
        m_res    = rf_reg[rd_ptr_reg];
        out_pop  = m_valid && m_ready;
        cnt_next = cnt_reg + {1'b0, push_n} - {2'b00, out_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            count_reg    <= '0;
            cand_reg     <= KW_ALL;
            finished_reg <= 1'b0;
            wr_ptr_reg   <= 2'd0;
            rd_ptr_reg   <= 2'd0;
            cnt_reg      <= 3'd0;
        end
        else
        begin
            if (fire)
            begin
                mode_reg     <= mode_next;
                count_reg    <= count_next;
                cand_reg     <= cand_next;
                finished_reg <= finished_next;
            end
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, out_pop};
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            rf_reg[wr_ptr_reg] <= slot0;
        end
        if (push_n == 2'd2)
        begin
            rf_reg[wr_ptr_reg + 2'd1] <= slot1;
        end
    end

    `STT_ASSERT_ALWAYS(a_buf_bound, cnt_reg <= 3'd4)
    `STT_ASSERT_NEXT(a_end_sticks, fire && q_item.eoi, finished_reg)
    `STT_ASSERT_ALWAYS(a_finished_idle, !finished_reg || (mode_reg == M_IDLE && count_reg == '0))

endmodule

`default_nettype wire

>>> src/source_text_tokenizer_unit.sv
// top level of the streaming source text tokenizer
// each beat is registered in the queue, and its results in the result buffer
// throughput: one character beat per cycle while the result buffer has room;
// the output port carries one result per cycle, and a beat may yield two results
// reset: asynchronous active low; scanner idle, counts zero, queue and result buffer empty
`default_nettype none

module source_text_tokenizer_unit import stt_pkg::*;
#(
    parameter int KEYWORD_COUNT = 18,
    parameter int LENGTH_BITS   = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_code
    input  wire logic        s_tuser,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // token_kind, lexeme_length, zero pad
    output logic             m_tlast
);

    item_t   front_item;
    logic    front_valid;
    logic    front_ready;
    item_t   q_item;
    logic    q_valid;
    logic    q_pop;
    result_t res;

    stt_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    stt_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (q_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop)
    );

    stt_back
    #(
        .KEYWORD_COUNT (KEYWORD_COUNT),
        .LENGTH_BITS   (LENGTH_BITS)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .m_res   (res),
        .m_valid (m_tvalid),
        .m_ready (m_tready)
    );

    always_comb
    begin
        m_tdata = {2'b00, res.len, res.kind};
        m_tlast = res.last;
    end

endmodule

`default_nettype wire
